>>> src/idti_pkg.sv
// ----------------------------------------------------------------------------
// Indent/dedent token inserter package
// Shared token kind codes, controller states and the command and status
// records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package idti_pkg;

  localparam logic [1:0] KIND_ORD = 2'd0;
  localparam logic [1:0] KIND_NL  = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  typedef enum logic [2:0] {
    OK_ORD = 3'd0,
    OK_NL  = 3'd1,
    OK_IND = 3'd2,
    OK_DED = 3'd3,
    OK_END = 3'd4,
    OK_ERR = 3'd5
  } out_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_IND,
    S_ERR,
    S_DED,
    S_LOAD,
    S_CHECK,
    S_TOK,
    S_NL,
    S_END_DED,
    S_END
  } state_t;

  typedef struct packed {
    logic      capture;
    logic      emit;
    out_kind_t emit_kind;
    logic      emit_last;
    logic      push;
    logic      pop;
    logic      load_top;
    logic      end_reset;
    logic      set_pending;
    logic      clr_pending;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pending;
    logic       col_gt_top;
    logic       col_eq_top;
    logic       count_gt1;
    logic       stack_full;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

>>> src/idti_dp.sv
// ----------------------------------------------------------------------------
// Indent/dedent token inserter datapath
// Holds the accepted token, the column stack in a memory with its top cached
// in a register, the pending newline flag and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module idti_dp #(
  parameter int MAX_LEVELS  = 32,
  parameter int COLUMN_BITS = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire idti_pkg::cmd_t   cmd,
  output idti_pkg::status_t     status,
  input  wire logic [1:0]       token_kind,
  input  wire logic [7:0]       token_code,
  input  wire logic [9:0]       column,
  input  wire logic [19:0]      line_number,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_kind,
  output logic [7:0]            out_code,
  output logic [9:0]            out_column,
  output logic [19:0]           out_line,
  output logic                  last_of_run
);
  import idti_pkg::*;

  localparam int CW = $clog2(MAX_LEVELS + 1);
  localparam int AW = $clog2(MAX_LEVELS);

  logic [1:0]             kind_r;
  logic [7:0]             code_r;
  logic [9:0]             col_r;
  logic [19:0]            line_r;
  logic                   pending;
  logic [CW-1:0]          count;
  logic [COLUMN_BITS-1:0] top_col;
  logic [COLUMN_BITS-1:0] col_c;
  logic [COLUMN_BITS-1:0] mem [MAX_LEVELS];
  logic [COLUMN_BITS-1:0] rd_data;
  logic                   rd_zero;
  logic [CW-1:0]          pop_addr;
  logic                   out_free;
  out_kind_t              kind_q;

  assign col_c    = COLUMN_BITS'(col_r);
  assign pop_addr = count - CW'(2);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    status.kind       = kind_r;
    status.pending    = pending;
    status.col_gt_top = col_c > top_col;
    status.col_eq_top = col_c == top_col;
    status.count_gt1  = count > CW'(1);
    status.stack_full = count == CW'(MAX_LEVELS);
    status.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= token_kind;
      code_r <= token_code;
      col_r  <= column;
      line_r <= line_number;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[AW-1:0]] <= col_c;
    end
    if (cmd.pop) begin
      rd_data <= mem[pop_addr[AW-1:0]];
      rd_zero <= pop_addr == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= CW'(1);
      top_col <= '0;
      pending <= 1'b0;
    end else if (cmd.end_reset) begin
      count   <= CW'(1);
      top_col <= '0;
      pending <= 1'b0;
    end else begin
      if (cmd.set_pending) begin
        pending <= 1'b1;
      end else if (cmd.clr_pending) begin
        pending <= 1'b0;
      end
      if (cmd.push) begin
        count   <= count + CW'(1);
        top_col <= col_c;
      end else if (cmd.pop) begin
        count <= count - CW'(1);
      end else if (cmd.load_top) begin
        top_col <= rd_zero ? '0 : rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_q      <= cmd.emit_kind;
      out_code    <= (cmd.emit_kind == OK_ORD) ? code_r : 8'd0;
      out_column  <= col_r;
      out_line    <= line_r;
      last_of_run <= cmd.emit_last;
    end
  end

  assign out_kind = kind_q;

endmodule

`default_nettype wire

>>> src/idti_ctrl.sv
// ----------------------------------------------------------------------------
// Indent/dedent token inserter controller
// Sequences one accepted request through its results: newline collapse,
// indent push, dedent pops with stack reads, error and end handling.
// ----------------------------------------------------------------------------
`default_nettype none

module idti_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire idti_pkg::status_t  status,
  output idti_pkg::cmd_t          cmd
);
  import idti_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.emit_kind = OK_ORD;
    in_stall      = state != S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.kind)
          KIND_NL: begin
            if (status.pending) begin
              state_next = S_IDLE;
            end else begin
              state_next = S_NL;
            end
          end
          KIND_ORD: begin
            if (!status.pending) begin
              state_next = S_TOK;
            end else begin
              cmd.clr_pending = 1'b1;
              if (status.col_gt_top) begin
                state_next = status.stack_full ? S_ERR : S_IND;
              end else if (!status.col_eq_top) begin
                state_next = S_DED;
              end else begin
                state_next = S_TOK;
              end
            end
          end
          KIND_END: begin
            state_next = S_END_DED;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_NL: begin
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = OK_NL;
          cmd.emit_last   = 1'b1;
          cmd.set_pending = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_IND: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OK_IND;
          cmd.push      = 1'b1;
          state_next    = S_TOK;
        end
      end
      S_ERR: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OK_ERR;
          state_next    = S_TOK;
        end
      end
      S_DED: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OK_DED;
          cmd.pop       = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_top = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (status.count_gt1 && !status.col_gt_top && !status.col_eq_top) begin
          state_next = S_DED;
        end else if (!status.col_eq_top) begin
          state_next = S_ERR;
        end else begin
          state_next = S_TOK;
        end
      end
      S_TOK: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OK_ORD;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_END_DED: begin
        if (!status.count_gt1) begin
          state_next = S_END;
        end else if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OK_DED;
          cmd.pop       = 1'b1;
        end
      end
      S_END: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OK_END;
          cmd.emit_last = 1'b1;
          cmd.end_reset = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/indent_dedent_token_inserter.sv
// ----------------------------------------------------------------------------
// Indent/dedent token inserter
// Turns a lexer token stream into one with NEWLINE, INDENT, DEDENT, END and
// indentation error results, using a stack of indentation columns.
//
// The input channel takes one token request (kind, code, column, line) when
// in_valid is high and in_stall is low. The output channel presents one
// result request at a time; it is taken when out_valid is high and out_stall
// is low, and last_of_run marks the final result of an input request.
// One request is handled at a time: the next is accepted only after the
// current one has issued all of its results. In a dedent run, each pop
// waits for a registered read of the column stack memory to refresh the
// cached top entry. End of input gives one DEDENT per open level, then
// END. A newline while one is pending and an unused kind give no result.
// Results leave through an output register; while out_stall holds a
// valid result there, the register holds and the sequencer waits before
// its next result. in_stall is high while a request is in progress.
// Reset empties the stack to its base column 0 and clears the pending
// newline; an END result does the same.
// ----------------------------------------------------------------------------
`default_nettype none

module indent_dedent_token_inserter #(
  parameter int MAX_LEVELS  = 32,
  parameter int COLUMN_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  token_kind,
  input  wire logic [7:0]  token_code,
  input  wire logic [9:0]  column,
  input  wire logic [19:0] line_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_code,
  output logic [9:0]       out_column,
  output logic [19:0]      out_line,
  output logic             last_of_run
);
  import idti_pkg::*;

  cmd_t    cmd;
  status_t status;

  idti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  idti_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .token_kind  (token_kind),
    .token_code  (token_code),
    .column      (column),
    .line_number (line_number),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_code    (out_code),
    .out_column  (out_column),
    .out_line    (out_line),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
